/* hdl/qvx_pkg.sv */
// ----------------------------------------------------------------------------
// qvx_pkg
// Shared types, constants and helper functions for the quad vertex expander.
// ----------------------------------------------------------------------------
package qvx_pkg;

    // Quarter-wave sine polynomial constants, Q15
    localparam logic [16:0] SIN_C1 = 17'd102944;
    localparam logic [16:0] SIN_C2 = 17'd42047;
    localparam logic [16:0] SIN_C3 = 17'd4640;
    localparam logic [16:0] Q15_ONE = 17'd32768;

    // Vertices per particle
    localparam int NUM_VERTS = 6;
    localparam logic [2:0] LAST_VERT = 3'(NUM_VERTS - 1);

    localparam logic [16:0] PROG_END = 17'd65536;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_END_X   = 3'd2,
        CFG_END_Y   = 3'd3,
        CFG_TEX_W   = 3'd4,
        CFG_TEX_H   = 3'd5,
        CFG_HAS_TEX = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [19:0] start_x;
        logic [19:0] start_y;
        logic [19:0] end_x;
        logic [19:0] end_y;
        logic [15:0] tex_w;
        logic [15:0] tex_h;
        logic        has_tex;
    } t_cfg;

    // Folded sine argument: magnitude argument and sign of the result
    typedef struct packed {
        logic        neg;
        logic [15:0] x;
    } t_arg;

    function automatic t_arg fold_angle(input logic [15:0] a);
        t_arg        r;
        logic [15:0] x;
        x     = {1'b0, a[13:0], 1'b0};
        r.neg = a[15];
        r.x   = a[14] ? (16'd32768 - x) : x;
        return r;
    endfunction

    // Output vertex index to quad corner: 0,1,2,0,2,3
    function automatic logic [1:0] corner_of(input logic [2:0] n);
        logic [1:0] c;
        unique case (n)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd1;
            3'd2:    c = 2'd2;
            3'd3:    c = 2'd0;
            3'd4:    c = 2'd2;
            3'd5:    c = 2'd3;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    // Q.24 to Q.8, round half up, saturate to signed 24 bits
    function automatic logic [23:0] to_vert(input logic signed [41:0] v);
        logic signed [41:0] w;
        logic signed [41:0] r;
        logic [23:0]        o;
        w = v + 42'sd32768;
        r = w >>> 16;
        if (r > 42'sd8388607) begin
            o = 24'h7FFFFF;
        end else if (r < -42'sd8388608) begin
            o = 24'h800000;
        end else begin
            o = r[23:0];
        end
        return o;
    endfunction

endpackage

/* hdl/particle_quad_vertex_expand_core.sv */
// An accepted particle passes the 7 compute stages and the output holding
// register before its first vertex. Throughput: one vertex per cycle while
// i_stall is low; the six vertex output sequencer sets this, the 7 compute
// stages take an item per cycle unless stalled. Reset: synchronous, active
// low; clears all valid bits, the vertex counter and the configuration registers.
// ----------------------------------------------------------------------------
// particle_quad_vertex_expand_core
// Expands a particle into the six vertices of a rotated, textured quad.
// ----------------------------------------------------------------------------
module particle_quad_vertex_expand_core
    import qvx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    // particle input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [23:0] i_pos_x,
    input  logic [23:0] i_pos_y,
    input  logic [15:0] i_angle,
    input  logic [16:0] i_progress,
    input  logic [31:0] i_color_in,
    // vertex output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_vert_x,
    output logic [23:0] o_vert_y,
    output logic [15:0] o_tex_u,
    output logic [15:0] o_tex_v,
    output logic [31:0] o_color_out,
    output logic        o_last
);

    t_cfg r_cfg;

    logic               en;
    logic               free;
    logic               f_valid;
    logic [19:0]        f_hx, f_hy;
    logic signed [16:0] f_sn, f_cs;
    logic [23:0]        f_px, f_py;
    logic [31:0]        f_col;
    logic               k_valid;
    logic signed [41:0] k_x [4];
    logic signed [41:0] k_y [4];
    logic [31:0]        k_col;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START_X: r_cfg.start_x <= i_cfg_data;
                CFG_START_Y: r_cfg.start_y <= i_cfg_data;
                CFG_END_X:   r_cfg.end_x   <= i_cfg_data;
                CFG_END_Y:   r_cfg.end_y   <= i_cfg_data;
                CFG_TEX_W:   r_cfg.tex_w   <= i_cfg_data[15:0];
                CFG_TEX_H:   r_cfg.tex_h   <= i_cfg_data[15:0];
                CFG_HAS_TEX: r_cfg.has_tex <= i_cfg_data[0];
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    // whole pipeline advances unless the last stage is full and can't unload
    assign en      = !k_valid || free;
    assign o_stall = !en;

    qvx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_cfg      (r_cfg),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_angle    (i_angle),
        .i_progress (i_progress),
        .i_color_in (i_color_in),
        .o_valid    (f_valid),
        .o_hx       (f_hx),
        .o_hy       (f_hy),
        .o_sn       (f_sn),
        .o_cs       (f_cs),
        .o_px       (f_px),
        .o_py       (f_py),
        .o_color    (f_col)
    );

    qvx_corner u_corner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_hx    (f_hx),
        .i_hy    (f_hy),
        .i_sn    (f_sn),
        .i_cs    (f_cs),
        .i_px    (f_px),
        .i_py    (f_py),
        .i_color (f_col),
        .o_valid (k_valid),
        .o_x     (k_x),
        .o_y     (k_y),
        .o_color (k_col)
    );

    qvx_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (k_valid && free),
        .i_x         (k_x),
        .i_y         (k_y),
        .i_color     (k_col),
        .i_cfg       (r_cfg),
        .i_stall     (i_stall),
        .o_free      (free),
        .o_valid     (o_valid),
        .o_vert_x    (o_vert_x),
        .o_vert_y    (o_vert_y),
        .o_tex_u     (o_tex_u),
        .o_tex_v     (o_tex_v),
        .o_color_out (o_color_out),
        .o_last      (o_last)
    );

endmodule

/* hdl/qvx_front.sv */
// ----------------------------------------------------------------------------
// qvx_front
// Stages 1-5: progress clamp, size lerp and quarter-wave sin/cos polynomial.
// ----------------------------------------------------------------------------
module qvx_front
    import qvx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_cfg               i_cfg,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic [15:0]        i_angle,
    input  logic [16:0]        i_progress,
    input  logic [31:0]        i_color_in,
    output logic               o_valid,
    output logic [19:0]        o_hx,
    output logic [19:0]        o_hy,
    output logic signed [16:0] o_sn,
    output logic signed [16:0] o_cs,
    output logic [23:0]        o_px,
    output logic [23:0]        o_py,
    output logic [31:0]        o_color
);

    // lane 0 = sine, lane 1 = cosine
    logic [4:0]  r_v;
    logic [15:0] r1_x [2];
    logic [1:0]  r1_n, r2_n, r3_n, r4_n;
    logic [16:0] r1_p;
    logic [15:0] r2_x [2], r3_x [2], r4_x [2];
    logic [15:0] r2_x2 [2], r3_x2 [2];
    logic [15:0] r3_t1 [2];
    logic [16:0] r4_t2 [2];
    logic [16:0] r5_s [2];
    logic [36:0] r2_lsx, r2_lex, r2_lsy, r2_ley;
    logic [19:0] r3_hx, r3_hy, r4_hx, r4_hy, r5_hx, r5_hy;
    logic [23:0] r1_px, r2_px, r3_px, r4_px, r5_px;
    logic [23:0] r1_py, r2_py, r3_py, r4_py, r5_py;
    logic [31:0] r1_c, r2_c, r3_c, r4_c, r5_c;

    t_arg        arg_s, arg_c;
    logic [16:0] p_clamp;
    logic [16:0] p_inv;
    logic [37:0] sum_x, sum_y;

    always_comb begin
        arg_s   = fold_angle(i_angle);
        arg_c   = fold_angle(i_angle + 16'd16384);
        p_clamp = (i_progress > PROG_END) ? PROG_END : i_progress;
        p_inv   = PROG_END - r1_p;
        sum_x   = 38'(r2_lsx) + 38'(r2_lex);
        sum_y   = 38'(r2_lsy) + 38'(r2_ley);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        logic [31:0] m1;
        logic [31:0] m2;
        logic [32:0] m3;
        logic [16:0] mag;
        if (i_en) begin
            // stage 1: fold angles, clamp progress
            r1_x[0] <= arg_s.x;
            r1_x[1] <= arg_c.x;
            r1_n    <= {arg_c.neg, arg_s.neg};
            r1_p    <= p_clamp;
            r1_px   <= i_pos_x;
            r1_py   <= i_pos_y;
            r1_c    <= i_color_in;
            // stage 2: x^2, lerp products
            r2_lsx <= 37'(i_cfg.start_x) * 37'(p_inv);
            r2_lex <= 37'(i_cfg.end_x) * 37'(r1_p);
            r2_lsy <= 37'(i_cfg.start_y) * 37'(p_inv);
            r2_ley <= 37'(i_cfg.end_y) * 37'(r1_p);
            r2_n   <= r1_n;
            r2_px  <= r1_px;
            r2_py  <= r1_py;
            r2_c   <= r1_c;
            // stage 3: lerp sum, first polynomial term
            r3_hx <= sum_x[35:16];
            r3_hy <= sum_y[35:16];
            r3_n  <= r2_n;
            r3_px <= r2_px;
            r3_py <= r2_py;
            r3_c  <= r2_c;
            // stage 4: second polynomial term
            r4_hx <= r3_hx;
            r4_hy <= r3_hy;
            r4_n  <= r3_n;
            r4_px <= r3_px;
            r4_py <= r3_py;
            r4_c  <= r3_c;
            // stage 5: final product, clamp, sign
            r5_hx <= r4_hx;
            r5_hy <= r4_hy;
            r5_px <= r4_px;
            r5_py <= r4_py;
            r5_c  <= r4_c;
            for (int l = 0; l < 2; l++) begin
                m1 = 32'(r1_x[l]) * 32'(r1_x[l]);
                r2_x[l]  <= r1_x[l];
                r2_x2[l] <= m1[30:15];
                m1 = 32'(r2_x2[l]) * 32'(SIN_C3);
                r3_x[l]  <= r2_x[l];
                r3_x2[l] <= r2_x2[l];
                r3_t1[l] <= 16'(SIN_C2 - m1[31:15]);
                m2 = 32'(r3_x2[l]) * 32'(r3_t1[l]);
                r4_x[l]  <= r3_x[l];
                r4_t2[l] <= SIN_C1 - m2[31:15];
                m3  = 33'(r4_x[l]) * 33'(r4_t2[l]);
                mag = (m3[32:16] > Q15_ONE) ? Q15_ONE : m3[32:16];
                r5_s[l] <= r4_n[l] ? (17'd0 - mag) : mag;
            end
        end
    end

    assign o_valid = r_v[4];
    assign o_hx    = r5_hx;
    assign o_hy    = r5_hy;
    assign o_sn    = signed'(r5_s[0]);
    assign o_cs    = signed'(r5_s[1]);
    assign o_px    = r5_px;
    assign o_py    = r5_py;
    assign o_color = r5_c;

endmodule

/* hdl/qvx_corner.sv */
// ----------------------------------------------------------------------------
// qvx_corner
// Stages 6-7: rotation products and the four corner positions in Q.24.
// ----------------------------------------------------------------------------
module qvx_corner
    import qvx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [19:0]        i_hx,
    input  logic [19:0]        i_hy,
    input  logic signed [16:0] i_sn,
    input  logic signed [16:0] i_cs,
    input  logic [23:0]        i_px,
    input  logic [23:0]        i_py,
    input  logic [31:0]        i_color,
    output logic               o_valid,
    output logic signed [41:0] o_x [4],
    output logic signed [41:0] o_y [4],
    output logic [31:0]        o_color
);

    logic [1:0]         r_v;
    logic signed [37:0] r6_a, r6_b, r6_c, r6_d;
    logic [23:0]        r6_px, r6_py;
    logic [31:0]        r6_col, r7_col;
    logic signed [41:0] r7_x [4];
    logic signed [41:0] r7_y [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[0], i_valid};
        end
    end

    // half size times sin/cos, then signed sums per corner
    always_ff @(posedge i_clk) begin
        logic signed [41:0] a, b, c, d, px, py;
        if (i_en) begin
            r6_a   <= $signed({1'b0, i_hx}) * i_cs;
            r6_b   <= $signed({1'b0, i_hy}) * i_sn;
            r6_c   <= $signed({1'b0, i_hx}) * i_sn;
            r6_d   <= $signed({1'b0, i_hy}) * i_cs;
            r6_px  <= i_px;
            r6_py  <= i_py;
            r6_col <= i_color;
            a  = 42'(r6_a);
            b  = 42'(r6_b);
            c  = 42'(r6_c);
            d  = 42'(r6_d);
            px = $signed({{2{r6_px[23]}}, r6_px, 16'd0});
            py = $signed({{2{r6_py[23]}}, r6_py, 16'd0});
            for (int k = 0; k < 4; k++) begin
                // corners 0 and 3 sit on the left, 0 and 1 on the top
                r7_x[k] <= ((k == 0 || k == 3) ? -a : a) - ((k < 2) ? -b : b) + px;
                r7_y[k] <= ((k == 0 || k == 3) ? -c : c) + ((k < 2) ? -d : d) + py;
            end
            r7_col <= r6_col;
        end
    end

    assign o_valid = r_v[1];
    assign o_x     = r7_x;
    assign o_y     = r7_y;
    assign o_color = r7_col;

endmodule

/* hdl/qvx_emit.sv */
// ----------------------------------------------------------------------------
// qvx_emit
// Rounds and saturates the corners into a holding register and sends the six
// triangle vertices of one particle, one per accepted output item.
// ----------------------------------------------------------------------------
module qvx_emit
    import qvx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic signed [41:0] i_x [4],
    input  logic signed [41:0] i_y [4],
    input  logic [31:0]        i_color,
    input  t_cfg               i_cfg,
    input  logic               i_stall,
    output logic               o_free,
    output logic               o_valid,
    output logic [23:0]        o_vert_x,
    output logic [23:0]        o_vert_y,
    output logic [15:0]        o_tex_u,
    output logic [15:0]        o_tex_v,
    output logic [31:0]        o_color_out,
    output logic               o_last
);

    logic        r_valid;
    logic [2:0]  r_cnt;
    logic [23:0] r_x [4];
    logic [23:0] r_y [4];
    logic [31:0] r_col;

    logic       fire;
    logic [1:0] c;

    always_comb begin
        fire   = r_valid && !i_stall;
        o_free = !r_valid || (fire && r_cnt == LAST_VERT);
        c      = corner_of(r_cnt);
    end

    // vertex counter and holding register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_cnt   <= '0;
        end else if (fire) begin
            if (r_cnt == LAST_VERT) begin
                r_valid <= 1'b0;
                r_cnt   <= '0;
            end else begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    // corner payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < 4; k++) begin
                r_x[k] <= to_vert(i_x[k]);
                r_y[k] <= to_vert(i_y[k]);
            end
            r_col <= i_color;
        end
    end

    assign o_valid     = r_valid;
    assign o_vert_x    = r_x[c];
    assign o_vert_y    = r_y[c];
    assign o_tex_u     = (i_cfg.has_tex && (c == 2'd1 || c == 2'd2)) ? i_cfg.tex_w : 16'd0;
    assign o_tex_v     = (i_cfg.has_tex && c[1]) ? i_cfg.tex_h : 16'd0;
    assign o_color_out = r_col;
    assign o_last      = r_cnt == LAST_VERT;

endmodule

/* hdl/qvx_checker.sv */
// ----------------------------------------------------------------------------
// qvx_checker
// Port-level checks of the vertex output of the quad expander.
// ----------------------------------------------------------------------------
module qvx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [23:0] o_vert_x,
    input logic [31:0] o_color_out,
    input logic        o_last
);

    // a stalled item stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output valid dropped under stall");

    // a stalled item keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_vert_x) && $stable(o_last))
        else $error("output payload changed under stall");

    // vertices of one particle follow each other with the same color
    a_same_particle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid && $stable(o_color_out))
        else $error("particle vertex run broken before last");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind particle_quad_vertex_expand_core qvx_checker u_qvx_checker (.*);
